// ===== design/psfd_pkg.sv =====
// Shared types and constants for the per-source flood detector.
`default_nettype none

package psfd_pkg;

   // request kinds, carried on req_tuser
   localparam logic [1:0] REQ_CHECK_RECORD = 2'd0;
   localparam logic [1:0] REQ_CHECK_ONLY   = 2'd1;
   localparam logic [1:0] REQ_RATE_QUERY   = 2'd2;

   // flood classes
   localparam logic [1:0] CLASS_OK     = 2'd0;
   localparam logic [1:0] CLASS_MINOR  = 2'd1;
   localparam logic [1:0] CLASS_SEVERE = 2'd2;

   // configuration register indexes
   localparam logic [1:0] CSR_WINDOW_SECONDS = 2'd0;
   localparam logic [1:0] CSR_MINOR_LIMIT    = 2'd1;
   localparam logic [1:0] CSR_SEVERE_LIMIT   = 2'd2;

   localparam int DEFAULT_TABLE_SLOTS = 64;

   localparam int KEY_W    = 32;
   localparam int TIME_W   = 48;
   localparam int TYPE_W   = 2;
   localparam int CLASS_W  = 2;
   localparam int ATT_W    = 7;
   localparam int WIN_S_W  = 16;
   localparam int LIMIT_W  = 7;
   localparam int WIN_MS_W = 26;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam int REQ_DATA_W    = 80;
   localparam int RSP_FIELDS_W  = 59;
   localparam int RSP_DATA_W    = 64;

   localparam int MS_PER_SECOND = 1000;
   localparam int ATT_MAX       = 127;

   localparam logic [WIN_S_W-1:0] WINDOW_RESET = 16'd10;
   localparam logic [LIMIT_W-1:0] MINOR_RESET  = 7'd15;
   localparam logic [LIMIT_W-1:0] SEVERE_RESET = 7'd30;

   typedef struct packed {
      logic clear;
      logic accept;
      logic load;
      logic read;
      logic commit;
      logic result;
   } psfd_cmd_type;

   typedef struct packed {
      logic addr_last;
      logic out_free;
   } psfd_stat_type;

endpackage

`default_nettype wire

// ===== design/psfd_ctrl.sv =====
// Sequencer for the clearing pass and the per-item table scan.
`default_nettype none

module psfd_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   output psfd_pkg::psfd_cmd_type      cmd,
   input  wire psfd_pkg::psfd_stat_type stat
);
   import psfd_pkg::*;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_LOAD,
      S_SCAN,
      S_DRAIN,
      S_COMMIT,
      S_RESULT
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR:  if (stat.addr_last) state_in = S_IDLE;
         S_IDLE:   if (req_tvalid) state_in = S_LOAD;
         S_LOAD:   state_in = S_SCAN;
         S_SCAN:   if (stat.addr_last) state_in = S_DRAIN;
         S_DRAIN:  state_in = S_COMMIT;
         S_COMMIT: state_in = S_RESULT;
         S_RESULT: if (stat.out_free) state_in = S_IDLE;
         default:  state_in = S_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      cmd        = '0;
      cmd.clear  = (state_ff == S_CLEAR);
      cmd.accept = (state_ff == S_IDLE) && req_tvalid;
      cmd.load   = (state_ff == S_LOAD);
      cmd.read   = (state_ff == S_SCAN);
      cmd.commit = (state_ff == S_COMMIT);
      cmd.result = (state_ff == S_RESULT);
   end

endmodule

`default_nettype wire

// ===== design/psfd_datapath.sv =====
// Slot table, scan accumulators, configuration registers and result register.
`default_nettype none

module psfd_datapath #(
   parameter int TABLE_SLOTS = psfd_pkg::DEFAULT_TABLE_SLOTS
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire psfd_pkg::psfd_cmd_type            cmd,
   output psfd_pkg::psfd_stat_type                stat,
   input  wire logic [psfd_pkg::TYPE_W-1:0]       req_tuser,
   input  wire logic [psfd_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  wire logic                              csr_wr_en,
   input  wire logic [psfd_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [psfd_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  wire logic                              rsp_tready,
   output logic                                   rsp_tvalid,
   output logic [psfd_pkg::RSP_DATA_W-1:0]        rsp_tdata
);
   import psfd_pkg::*;

   localparam int AW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
   localparam int CW = $clog2(TABLE_SLOTS + 1);
   localparam int XW = (CW > ATT_W) ? CW : ATT_W;
   localparam logic [AW-1:0] LAST_ADDR = AW'(TABLE_SLOTS - 1);
   localparam logic [XW-1:0] ATT_SAT   = XW'(ATT_MAX);

   // slot table
   logic              slot_valid_mem [TABLE_SLOTS];
   logic [KEY_W-1:0]  slot_key_mem   [TABLE_SLOTS];
   logic [TIME_W-1:0] slot_time_mem  [TABLE_SLOTS];

   // configuration
   logic [WIN_S_W-1:0]  window_ff;
   logic [LIMIT_W-1:0]  minor_ff;
   logic [LIMIT_W-1:0]  severe_ff;
   logic [WIN_MS_W-1:0] win_ms;

   // item
   logic [TYPE_W-1:0] type_ff;
   logic [KEY_W-1:0]  key_ff;
   logic [TIME_W-1:0] now_ff;
   logic [TIME_W-1:0] lim_ff;
   logic              exp_en_ff;

   // scan
   logic [AW-1:0]     addr_ff;
   logic [AW-1:0]     addr_in;
   logic              rd_pend_ff;
   logic [AW-1:0]     rd_addr_ff;
   logic              rd_valid_ff;
   logic [KEY_W-1:0]  rd_key_ff;
   logic [TIME_W-1:0] rd_time_ff;
   logic [CW-1:0]     n_ff;
   logic [TIME_W-1:0] lo_ff;
   logic [TIME_W-1:0] hi_ff;
   logic              free_found_ff;
   logic [AW-1:0]     free_idx_ff;

   // result
   logic                  rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;

   logic [TIME_W:0] lim_wide;
   logic            expire;
   logic            live;
   logic            match;
   logic            rec_we;
   logic            val_we;
   logic [AW-1:0]   val_waddr;
   logic            val_wdata;
   logic            out_free;

   logic [XW-1:0]       n_x;
   logic [XW-1:0]       minor_x;
   logic [XW-1:0]       severe_x;
   logic [CLASS_W-1:0]  cls;
   logic                hit;
   logic [ATT_W-1:0]    att;
   logic [TIME_W-1:0]   span;
   logic                full;
   logic                is_check;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= WINDOW_RESET;
         minor_ff  <= MINOR_RESET;
         severe_ff <= SEVERE_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_WINDOW_SECONDS: window_ff <= csr_wdata;
            CSR_MINOR_LIMIT:    minor_ff  <= csr_wdata[LIMIT_W-1:0];
            CSR_SEVERE_LIMIT:   severe_ff <= csr_wdata[LIMIT_W-1:0];
            default:            ;
         endcase
      end
   end

   assign win_ms = WIN_MS_W'(window_ff) * WIN_MS_W'(MS_PER_SECOND);

   // latch item, then form the expiry threshold
   assign lim_wide = {1'b0, now_ff} - (TIME_W + 1)'(win_ms);
   assign is_check = (type_ff == REQ_CHECK_RECORD) || (type_ff == REQ_CHECK_ONLY);

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         type_ff <= req_tuser;
         key_ff  <= req_tdata[KEY_W-1:0];
         now_ff  <= req_tdata[KEY_W +: TIME_W];
      end
      if (cmd.load) begin
         lim_ff    <= lim_wide[TIME_W-1:0];
         exp_en_ff <= is_check && !lim_wide[TIME_W];
      end
   end

   // slot address counter, shared by the clearing pass and the scan
   always_comb begin
      addr_in = addr_ff;
      if (cmd.load) begin
         addr_in = '0;
      end else if (cmd.clear || cmd.read) begin
         addr_in = (addr_ff == LAST_ADDR) ? '0 : addr_ff + AW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff    <= '0;
         rd_pend_ff <= 1'b0;
      end else begin
         addr_ff    <= addr_in;
         rd_pend_ff <= cmd.read;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.read) begin
         rd_valid_ff <= slot_valid_mem[addr_ff];
         rd_key_ff   <= slot_key_mem[addr_ff];
         rd_time_ff  <= slot_time_mem[addr_ff];
         rd_addr_ff  <= addr_ff;
      end
   end

   // one slot a cycle: expire, count, track span and the lowest free slot
   assign expire = rd_pend_ff && rd_valid_ff && exp_en_ff && (rd_time_ff < lim_ff);
   assign live   = rd_valid_ff && !expire;
   assign match  = rd_pend_ff && live && (rd_key_ff == key_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         free_found_ff <= 1'b0;
      end else if (cmd.load) begin
         free_found_ff <= 1'b0;
      end else if (rd_pend_ff && !live && !free_found_ff) begin
         free_found_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         n_ff  <= '0;
         lo_ff <= '1;
         hi_ff <= '0;
      end else if (match) begin
         n_ff <= n_ff + CW'(1);
         if (rd_time_ff < lo_ff) lo_ff <= rd_time_ff;
         if (rd_time_ff > hi_ff) hi_ff <= rd_time_ff;
      end
      if (rd_pend_ff && !live && !free_found_ff) begin
         free_idx_ff <= rd_addr_ff;
      end
   end

   // table writes: clearing pass, expiry, new record
   assign rec_we = cmd.commit && (type_ff == REQ_CHECK_RECORD) && free_found_ff;

   always_comb begin
      val_we    = 1'b0;
      val_waddr = addr_ff;
      val_wdata = 1'b0;
      if (cmd.clear) begin
         val_we = 1'b1;
      end else if (expire) begin
         val_we    = 1'b1;
         val_waddr = rd_addr_ff;
      end else if (rec_we) begin
         val_we    = 1'b1;
         val_waddr = free_idx_ff;
         val_wdata = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (val_we) begin
         slot_valid_mem[val_waddr] <= val_wdata;
      end
      if (rec_we) begin
         slot_key_mem[free_idx_ff]  <= key_ff;
         slot_time_mem[free_idx_ff] <= now_ff;
      end
   end

   // classify
   assign n_x      = XW'(n_ff);
   assign minor_x  = XW'(minor_ff);
   assign severe_x = XW'(severe_ff);

   always_comb begin
      cls  = CLASS_OK;
      hit  = 1'b0;
      att  = '0;
      span = '0;
      full = 1'b0;
      if (is_check || (type_ff == REQ_RATE_QUERY)) begin
         att = (n_x > ATT_SAT) ? ATT_W'(ATT_MAX) : n_x[ATT_W-1:0];
      end
      if (is_check) begin
         if (n_x >= severe_x) begin
            cls = CLASS_SEVERE;
            hit = (n_x == severe_x);
         end else if (n_x >= minor_x) begin
            cls = CLASS_MINOR;
            hit = (n_x == minor_x);
         end
         full = (type_ff == REQ_CHECK_RECORD) && !free_found_ff;
      end else if ((type_ff == REQ_RATE_QUERY) && (n_ff != '0)) begin
         span = hi_ff - lo_ff;
      end
   end

   // result register
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.result && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.result && out_free) begin
         rsp_data_ff <= RSP_DATA_W'({full, span, att, hit, cls});
      end
   end

   assign rsp_tvalid     = rsp_valid_ff;
   assign rsp_tdata      = rsp_data_ff;
   assign stat.addr_last = (addr_ff == LAST_ADDR);
   assign stat.out_free  = out_free;

endmodule

`default_nettype wire

// ===== design/per_source_flood_detector_core.sv =====
// Top level of the per-source flood detector.
`default_nettype none

// Keeps a table of TABLE_SLOTS (source key, ms timestamp) records. A check
// expires old records, counts those of the key and classifies the count; a
// check-and-record request also stores a record in the lowest free slot; a rate
// query reports count and span without expiring. The slot memory has one read
// port and is scanned one slot a cycle; after the item is accepted the block
// steps through its load, scan, drain, commit and result states, and rsp_tvalid
// rises once the result is written to the output register. Only then can the
// next item be taken. A stalled result holds the block in its result state until
// the output register is free. After reset a clearing pass over all slots runs
// with req_tready low. A finished result waits in an output register while the
// next item is taken.
module per_source_flood_detector_core #(
   parameter int TABLE_SLOTS = psfd_pkg::DEFAULT_TABLE_SLOTS
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // source_key [31:0], now_ms [79:32]
   input  wire logic [psfd_pkg::REQ_DATA_W-1:0]   req_tdata,
   // req_type [1:0]
   input  wire logic [psfd_pkg::TYPE_W-1:0]       req_tuser,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // flood_class [1:0], hit_limit [2], attempts [9:3], span_ms [57:10],
   // table_full [58], zero [63:59]
   output logic [psfd_pkg::RSP_DATA_W-1:0]        rsp_tdata,
   input  wire logic                              csr_wr_en,
   input  wire logic [psfd_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [psfd_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import psfd_pkg::*;

   psfd_cmd_type  cmd;
   psfd_stat_type stat;

   psfd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .cmd        (cmd),
      .stat       (stat)
   );

   psfd_datapath #(
      .TABLE_SLOTS (TABLE_SLOTS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

`default_nettype wire

// ===== design/psfd_checker.sv =====
// Port-level checks for the per-source flood detector, bound to the top level.
`default_nettype none

module psfd_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            req_tvalid,
   input wire logic                            req_tready,
   input wire logic                            rsp_tvalid,
   input wire logic                            rsp_tready,
   input wire logic [psfd_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import psfd_pkg::*;

   // hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // one item at a time
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("item taken while another is at work");

   a_class_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[1:0] != 2'd3)
      else $error("bad flood class");

   a_hit_class: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[2] |-> rsp_tdata[1:0] != CLASS_OK)
      else $error("limit hit on an ok class");

   a_span_query: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[57:10] != 48'd0)
         |-> rsp_tdata[1:0] == CLASS_OK && !rsp_tdata[58] && !rsp_tdata[2])
      else $error("span on a check result");

endmodule

bind per_source_flood_detector_core psfd_checker u_psfd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire
